// File: hw/rtl/lfc_pkg.sv
// Package for the LED frame crossfade core: item codes, register map,
// controller states and reset values. No dependencies.
package lfc_pkg;

    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;
    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 10;
    localparam int STEP_W  = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE  = 3'd0,
        FN_COMMIT = 3'd1,
        FN_CLEAR  = 3'd2,
        FN_TICK   = 3'd3,
        FN_READ   = 3'd4
    } func_t;

    localparam logic REG_FADE_LEN      = 1'b0;
    localparam logic REG_STEP_INTERVAL = 1'b1;

    localparam logic [CHAN_W-1:0] FADE_LEN_RST      = 8'd50;
    localparam logic [CHAN_W-1:0] STEP_INTERVAL_RST = 8'd10;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_ZERO,
        ST_LOAD,
        ST_COPY,
        ST_DRAIN,
        ST_BL_RD,
        ST_BL_MUL,
        ST_BL_DIV,
        ST_BL_WR
    } state_t;

endpackage

// File: hw/rtl/led_frame_crossfade_core.sv
// LED frame crossfade core: incoming, fade and shown frame stores with a
// sweep controller and a three-lane blend divider. Depends on lfc_pkg, lfc_ram.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | func, pixel_index, in_red/green/blue
//  m_      | out       | m_valid / m_ready  | out_red/green/blue, fade flags
//  apb     | in        | psel/penable/pwrite| fade_len (0x0), step_interval (0x4)
//
// Writes, ticks without a step and unused codes: one beat a cycle; a stalled m_
// side holds s_ready low. Reads wait in ST_READ for the shown store's registered
// read port. Commit, fade-out start and final copy: a sweep over every pixel
// (ST_LOAD or ST_COPY, then ST_DRAIN). Clear without an image: an ST_ZERO sweep.
// A step tick: per pixel ST_BL_RD, ST_BL_MUL, the eight-step restoring divide
// in ST_BL_DIV on all three lanes at once, then ST_BL_WR. After reset a clearing
// pass zeroes the incoming and shown stores; no beat is taken meanwhile.
module led_frame_crossfade_core #(
    parameter int PIXEL_COUNT = 900
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input beats
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lfc_pkg::FUNC_W-1:0]  s_func,
    input  logic [lfc_pkg::INDEX_W-1:0] s_pixel_index,
    input  logic [lfc_pkg::CHAN_W-1:0]  s_in_red,
    input  logic [lfc_pkg::CHAN_W-1:0]  s_in_green,
    input  logic [lfc_pkg::CHAN_W-1:0]  s_in_blue,
    // result beats
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lfc_pkg::CHAN_W-1:0]  m_out_red,
    output logic [lfc_pkg::CHAN_W-1:0]  m_out_green,
    output logic [lfc_pkg::CHAN_W-1:0]  m_out_blue,
    output logic                        m_fade_running,
    output logic                        m_step_advanced,
    output logic                        m_fade_completed,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lfc_pkg::*;

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

    // ---------------- configuration registers
    logic [CHAN_W-1:0] fade_len_reg, step_interval_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_STEP_INTERVAL) ? {24'd0, step_interval_reg}
                                                    : {24'd0, fade_len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_len_reg      <= FADE_LEN_RST;
            step_interval_reg <= STEP_INTERVAL_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_STEP_INTERVAL) begin
                step_interval_reg <= pwdata[CHAN_W-1:0];
            end else begin
                fade_len_reg <= pwdata[CHAN_W-1:0];
            end
        end
    end

    // zero registers count as one
    logic [CHAN_W-1:0] n_eff, iv_eff;
    assign n_eff  = (fade_len_reg == '0) ? CHAN_W'(1) : fade_len_reg;
    assign iv_eff = (step_interval_reg == '0) ? CHAN_W'(1) : step_interval_reg;

    // ---------------- frame stores
    logic               inc_we, shw_we, fad_we;
    logic [AW-1:0]      inc_waddr, shw_waddr, fad_waddr;
    logic [AW-1:0]      inc_raddr, shw_raddr, fad_raddr;
    logic [PIXEL_W-1:0] inc_wdata, shw_wdata, inc_rdata, shw_rdata;
    logic [2*PIXEL_W-1:0] fad_wdata, fad_rdata;   // start in upper half, goal lower

    lfc_ram #(.WIDTH(PIXEL_W), .DEPTH(PIXEL_COUNT)) u_incoming (
        .aclk(aclk), .we(inc_we), .waddr(inc_waddr), .wdata(inc_wdata),
        .raddr(inc_raddr), .rdata(inc_rdata)
    );
    lfc_ram #(.WIDTH(PIXEL_W), .DEPTH(PIXEL_COUNT)) u_shown (
        .aclk(aclk), .we(shw_we), .waddr(shw_waddr), .wdata(shw_wdata),
        .raddr(shw_raddr), .rdata(shw_rdata)
    );
    lfc_ram #(.WIDTH(2*PIXEL_W), .DEPTH(PIXEL_COUNT)) u_fade (
        .aclk(aclk), .we(fad_we), .waddr(fad_waddr), .wdata(fad_wdata),
        .raddr(fad_raddr), .rdata(fad_rdata)
    );

    // ---------------- control and fade state
    state_t              state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic                active_reg, active_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CHAN_W-1:0]   tick_reg, tick_next;
    logic                image_reg, image_next;
    logic                pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]       pipe_addr_reg, pipe_addr_next;
    logic                pipe_copy_reg, pipe_copy_next;
    logic                goal_in_reg, goal_in_next;
    logic [CHAN_W-1:0]   blend_k_reg, blend_k_next;
    logic [2:0]          div_cnt_reg, div_cnt_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [CHAN_W-1:0]   rem_reg [3];
    logic [CHAN_W-1:0]   rem_next [3];
    logic [CHAN_W-1:0]   lo_reg [3];
    logic [CHAN_W-1:0]   lo_next [3];

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0]  m_color_reg, m_color_next;
    logic                m_run_reg, m_run_next;
    logic                m_adv_reg, m_adv_next;
    logic                m_done_reg, m_done_next;

    logic              accept, idx_ok;
    logic [IW-1:0]     idx_ext;
    logic [AW-1:0]     idx_addr;
    logic [CHAN_W-1:0] tick_inc;
    logic [STEP_W-1:0] step_inc;

    assign idx_ext  = IW'(s_pixel_index);
    assign idx_addr = idx_ext[AW-1:0];
    assign idx_ok   = 32'(s_pixel_index) < PIXEL_COUNT;
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign tick_inc = tick_reg + CHAN_W'(1);
    assign step_inc = step_reg + STEP_W'(1);

    always_comb begin
        logic [2*CHAN_W-1:0] num;
        logic [CHAN_W:0]     trial;
        logic [CHAN_W-1:0]   s_c, g_c;

        num   = '0;
        trial = '0;
        s_c   = '0;
        g_c   = '0;

        state_next      = state_reg;
        addr_next       = addr_reg;
        active_next     = active_reg;
        step_next       = step_reg;
        tick_next       = tick_reg;
        image_next      = image_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = addr_reg;
        pipe_copy_next  = pipe_copy_reg;
        goal_in_next    = goal_in_reg;
        blend_k_next    = blend_k_reg;
        div_cnt_next    = div_cnt_reg;
        rd_ok_next      = rd_ok_reg;
        rem_next        = rem_reg;
        lo_next         = lo_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_color_next = m_color_reg;
        m_run_next   = m_run_reg;
        m_adv_next   = m_adv_reg;
        m_done_next  = m_done_reg;

        inc_we    = 1'b0;
        inc_waddr = addr_reg;
        inc_wdata = '0;
        inc_raddr = addr_reg;
        shw_we    = 1'b0;
        shw_waddr = addr_reg;
        shw_wdata = '0;
        shw_raddr = addr_reg;
        fad_we    = 1'b0;
        fad_waddr = pipe_addr_reg;
        fad_wdata = {shw_rdata, goal_in_reg ? inc_rdata : PIXEL_W'(0)};
        fad_raddr = addr_reg;

        // retire a sweep beat read in the previous cycle
        if (pipe_valid_reg) begin
            if (pipe_copy_reg) begin
                shw_we    = 1'b1;
                shw_waddr = pipe_addr_reg;
                shw_wdata = fad_rdata[PIXEL_W-1:0];
            end else begin
                fad_we = 1'b1;
            end
        end

        unique case (state_reg)
            ST_INIT: begin
                inc_we = 1'b1;
                shw_we = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                shw_raddr = idx_addr;
                addr_next = '0;
                if (accept) begin
                    m_valid_next = 1'b1;
                    m_color_next = '0;
                    m_adv_next   = 1'b0;
                    m_done_next  = 1'b0;
                    m_run_next   = active_reg;
                    case (s_func)
                        FN_WRITE: begin
                            inc_we    = idx_ok;
                            inc_waddr = idx_addr;
                            inc_wdata = {s_in_red, s_in_green, s_in_blue};
                        end
                        FN_COMMIT: begin
                            active_next  = 1'b1;
                            step_next    = '0;
                            tick_next    = '0;
                            image_next   = 1'b1;
                            goal_in_next = 1'b1;
                            m_run_next   = 1'b1;
                            state_next   = ST_LOAD;
                        end
                        FN_CLEAR: begin
                            image_next = 1'b0;
                            if (image_reg) begin
                                active_next  = 1'b1;
                                step_next    = '0;
                                tick_next    = '0;
                                goal_in_next = 1'b0;
                                m_run_next   = 1'b1;
                                state_next   = ST_LOAD;
                            end else begin
                                state_next = ST_ZERO;
                            end
                        end
                        FN_TICK: begin
                            if (active_reg) begin
                                tick_next = tick_inc;
                                if (tick_inc >= iv_eff) begin
                                    tick_next = '0;
                                    step_next = step_inc;
                                    if (step_inc > STEP_W'(n_eff)) begin
                                        active_next = 1'b0;
                                        m_run_next  = 1'b0;
                                        m_done_next = 1'b1;
                                        state_next  = ST_COPY;
                                    end else begin
                                        blend_k_next = step_inc[CHAN_W-1:0];
                                        m_adv_next   = 1'b1;
                                        state_next   = ST_BL_RD;
                                    end
                                end
                            end
                        end
                        FN_READ: begin
                            // hold the result back until the shown store answers
                            m_valid_next = 1'b0;
                            rd_ok_next   = idx_ok;
                            state_next   = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_color_next = rd_ok_reg ? shw_rdata : PIXEL_W'(0);
                state_next   = ST_IDLE;
            end
            ST_ZERO: begin
                shw_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD, ST_COPY: begin
                pipe_valid_next = 1'b1;
                pipe_copy_next  = (state_reg == ST_COPY);
                addr_next       = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_BL_RD: begin
                state_next = ST_BL_MUL;
            end
            ST_BL_MUL: begin
                // s*(n-k) + g*k stays below 256*n, so the high byte is below n
                for (int c = 0; c < 3; c++) begin
                    s_c = fad_rdata[PIXEL_W + CHAN_W*c +: CHAN_W];
                    g_c = fad_rdata[CHAN_W*c +: CHAN_W];
                    num = (2*CHAN_W)'(s_c * (n_eff - blend_k_reg))
                        + (2*CHAN_W)'(g_c * blend_k_reg);
                    rem_next[c] = num[2*CHAN_W-1:CHAN_W];
                    lo_next[c]  = num[CHAN_W-1:0];
                end
                div_cnt_next = '0;
                state_next   = ST_BL_DIV;
            end
            ST_BL_DIV: begin
                // one restoring step a cycle; quotient shifts into lo
                for (int c = 0; c < 3; c++) begin
                    trial = {rem_reg[c], lo_reg[c][CHAN_W-1]};
                    if (trial >= (CHAN_W+1)'(n_eff)) begin
                        rem_next[c] = CHAN_W'(trial - (CHAN_W+1)'(n_eff));
                        lo_next[c]  = {lo_reg[c][CHAN_W-2:0], 1'b1};
                    end else begin
                        rem_next[c] = trial[CHAN_W-1:0];
                        lo_next[c]  = {lo_reg[c][CHAN_W-2:0], 1'b0};
                    end
                end
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'd7) begin
                    state_next = ST_BL_WR;
                end
            end
            ST_BL_WR: begin
                shw_we    = 1'b1;
                shw_wdata = {lo_reg[2], lo_reg[1], lo_reg[0]};
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_BL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            addr_reg       <= '0;
            active_reg     <= 1'b0;
            step_reg       <= '0;
            tick_reg       <= '0;
            image_reg      <= 1'b0;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            active_reg     <= active_next;
            step_reg       <= step_next;
            tick_reg       <= tick_next;
            image_reg      <= image_next;
            pipe_valid_reg <= pipe_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_addr_reg <= pipe_addr_next;
        pipe_copy_reg <= pipe_copy_next;
        goal_in_reg   <= goal_in_next;
        blend_k_reg   <= blend_k_next;
        div_cnt_reg   <= div_cnt_next;
        rd_ok_reg     <= rd_ok_next;
        rem_reg       <= rem_next;
        lo_reg        <= lo_next;
        m_color_reg   <= m_color_next;
        m_run_reg     <= m_run_next;
        m_adv_reg     <= m_adv_next;
        m_done_reg    <= m_done_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_out_red        = m_color_reg[3*CHAN_W-1:2*CHAN_W];
    assign m_out_green      = m_color_reg[2*CHAN_W-1:CHAN_W];
    assign m_out_blue       = m_color_reg[CHAN_W-1:0];
    assign m_fade_running   = m_run_reg;
    assign m_step_advanced  = m_adv_reg;
    assign m_fade_completed = m_done_reg;

endmodule

// File: hw/rtl/lfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 900
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lfc_checker.sv
// Port-level checks for the LED frame crossfade core and their bind.
// Depends on lfc_pkg and led_frame_crossfade_core.
module lfc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [lfc_pkg::CHAN_W-1:0]  m_out_red,
    input logic                        m_fade_running,
    input logic                        m_step_advanced,
    input logic                        m_fade_completed,
    input logic                        pready
);

    // completing beat: fade no longer running, no step flagged
    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fade_completed |-> !m_fade_running && !m_step_advanced)
        else $error("completion beat still shows a running fade");

    // an advancing step leaves the fade running
    a_step_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_advanced |-> m_fade_running)
        else $error("step beat without a running fade");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red))
        else $error("result beat dropped or changed under stall");

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat after reset");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind led_frame_crossfade_core lfc_checker u_lfc_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_out_red(m_out_red), .m_fade_running(m_fade_running),
    .m_step_advanced(m_step_advanced), .m_fade_completed(m_fade_completed),
    .pready(pready)
);
